@@ design/mlss_pkg.sv @@
// shared constants and types for the modulated led sensor scanner
package mlss_pkg;

    localparam int SENSOR_COUNT = 10;
    localparam int WAIT_STATES  = 4;

    localparam int ADDR_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int SAMPLE_W = 12;
    localparam int DARK_W   = 13;
    localparam int CURSOR_W = 4;
    localparam int PHASE_W  = 7;
    localparam int MODE_W   = 2;
    localparam int FILT_W   = DARK_W + SAMPLE_W;

    localparam logic [DARK_W-1:0]   DARK_RESET    = 13'd4096;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 12'd4095;
    localparam logic [31:0]         PATTERN_RESET = 32'hA5A5A5A5;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF       = 2'd0,
        MODE_ON        = 2'd1,
        MODE_ALTERNATE = 2'd2,
        MODE_LFSR      = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC
    } t_state;

endpackage

@@ design/mlss_ram.sv @@
// generic single write port ram with registered read
module mlss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/modulated_led_sensor_scanner_unit.sv @@
// top level of the modulated led sensor scanner with ambient light rejection
// Each input item is one 12-bit ADC sample. A sample at the start of a frame picks the LED
// level from led_mode and produces one result item per sensor (SENSOR_COUNT items, the last
// marked), each via a read state that reads the sample and filter memories at that sensor
// and a calc state that updates its 7/8 filters, writes them back and registers the result.
// Any other sample (wait state or store) gives a single result in the cycle after it is
// accepted; a store sample is also written to the LED-on or LED-off memory. A new sample is
// taken only when the sequencer is idle and the output register is free or being emptied.
// Writing led_mode clears all state at once; unwritten memory entries read as reset values.
module modulated_led_sensor_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_has_values,
    output logic [3:0]  o_sensor_index,
    output logic [11:0] o_raw_difference,
    output logic [11:0] o_filtered_difference,
    output logic [3:0]  o_next_channel,
    output logic        o_led_drive,
    output logic        o_last
);

    localparam int N  = mlss_pkg::SENSOR_COUNT;
    localparam int AW = mlss_pkg::ADDR_W;

    // control state
    mlss_pkg::t_state                  r_state, n_state;
    mlss_pkg::t_mode                   r_mode;
    logic [mlss_pkg::PHASE_W-1:0]      r_phase;
    logic                              r_led;
    logic [mlss_pkg::CURSOR_W-1:0]     r_cursor;
    logic [31:0]                       r_pattern;
    logic [AW-1:0]                     r_idx;
    logic [N-1:0]                      r_dark_vld, r_lit_vld, r_filt_vld;

    // output register
    logic        r_o_valid;
    logic        r_has_values;
    logic [3:0]  r_sensor_index;
    logic [11:0] r_raw;
    logic [11:0] r_filt;
    logic [3:0]  r_next_ch;
    logic        r_led_drive;
    logic        r_last;

    logic slot_free, in_acc, frame_start, rd_en, calc_go, idx_last;
    logic store_we;
    logic [mlss_pkg::CURSOR_W-1:0] cur_inc;
    logic                          cur_wrap;
    logic [31:0]                   n_pattern;
    logic                          n_led;

    logic [mlss_pkg::SAMPLE_W-1:0] rd_dark, rd_lit;
    logic [mlss_pkg::FILT_W-1:0]   rd_filt, wr_filt;
    logic [mlss_pkg::DARK_W-1:0]   df_old, ds, df_new;
    logic [mlss_pkg::SAMPLE_W-1:0] lf_old, ls, lf_new;
    logic [15:0]                   df_sum;
    logic [14:0]                   lf_sum;

    function automatic logic [11:0] clamp_diff(input logic [12:0] a, input logic [11:0] b);
        logic [13:0] d;
        d = {1'b0, a} - {2'b00, b};
        if (d[13]) begin
            return '0;
        end else if (d[12]) begin
            return mlss_pkg::SAMPLE_MAX;
        end else begin
            return d[11:0];
        end
    endfunction

    assign slot_free   = !r_o_valid || !i_stall;
    assign o_stall     = !((r_state == mlss_pkg::ST_IDLE) && slot_free);
    assign in_acc      = i_valid && !o_stall;
    assign frame_start = (r_phase == '0);
    assign idx_last    = (r_idx == AW'(N - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlss_pkg::ST_IDLE: begin
                if (in_acc && frame_start) begin
                    n_state = mlss_pkg::ST_READ;
                end
            end
            mlss_pkg::ST_READ: begin
                n_state = mlss_pkg::ST_CALC;
            end
            mlss_pkg::ST_CALC: begin
                if (slot_free) begin
                    n_state = idx_last ? mlss_pkg::ST_IDLE : mlss_pkg::ST_READ;
                end
            end
            default: begin
                n_state = mlss_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        rd_en   = 1'b0;
        calc_go = 1'b0;
        case (r_state)
            mlss_pkg::ST_READ: rd_en   = 1'b1;
            mlss_pkg::ST_CALC: calc_go = slot_free;
            default: begin
                rd_en   = 1'b0;
                calc_go = 1'b0;
            end
        endcase
    end

    // led level for a new frame
    always_comb begin
        n_pattern = r_pattern;
        n_led     = 1'b0;
        case (r_mode)
            mlss_pkg::MODE_OFF: n_led = 1'b0;
            mlss_pkg::MODE_ON:  n_led = 1'b1;
            mlss_pkg::MODE_ALTERNATE: begin
                n_pattern = r_pattern + 32'd1;
                n_led     = n_pattern[0];
            end
            mlss_pkg::MODE_LFSR: begin
                n_led     = r_pattern[31] ^ r_pattern[21] ^ r_pattern[1] ^ r_pattern[0];
                n_pattern = {r_pattern[30:0], n_led};
            end
            default: n_led = 1'b0;
        endcase
    end

    assign cur_inc  = r_cursor + 4'd1;
    assign cur_wrap = ({1'b0, cur_inc} >= 5'(N)) || (cur_inc == '0);
    assign store_we = in_acc && !frame_start && (r_phase >= 7'(mlss_pkg::WAIT_STATES))
                      && ({1'b0, r_cursor} < 5'(N));

    // filter update, unwritten entries take their reset value
    always_comb begin
        df_old = r_filt_vld[r_idx] ? rd_filt[mlss_pkg::FILT_W-1:mlss_pkg::SAMPLE_W]
                                   : mlss_pkg::DARK_RESET;
        lf_old = r_filt_vld[r_idx] ? rd_filt[mlss_pkg::SAMPLE_W-1:0] : '0;
        ds     = r_dark_vld[r_idx] ? {1'b0, rd_dark} : mlss_pkg::DARK_RESET;
        ls     = r_lit_vld[r_idx] ? rd_lit : '0;
        df_sum = {df_old, 3'b000} - {3'b000, df_old} + {3'b000, ds};
        lf_sum = {lf_old, 3'b000} - {3'b000, lf_old} + {3'b000, ls};
        df_new = df_sum[15:3];
        lf_new = lf_sum[14:3];
    end

    assign wr_filt = {df_new, lf_new};

    mlss_ram #(.WIDTH(mlss_pkg::SAMPLE_W), .DEPTH(N)) u_dark_ram (
        .i_clk   (i_clk),
        .i_we    (store_we && !r_led),
        .i_waddr (r_cursor[AW-1:0]),
        .i_wdata (i_sample),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_dark)
    );

    mlss_ram #(.WIDTH(mlss_pkg::SAMPLE_W), .DEPTH(N)) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (store_we && r_led),
        .i_waddr (r_cursor[AW-1:0]),
        .i_wdata (i_sample),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_lit)
    );

    mlss_ram #(.WIDTH(mlss_pkg::FILT_W), .DEPTH(N)) u_filt_ram (
        .i_clk   (i_clk),
        .i_we    (calc_go),
        .i_waddr (r_idx),
        .i_wdata (wr_filt),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_filt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mlss_pkg::ST_IDLE;
            r_mode     <= mlss_pkg::MODE_ALTERNATE;
            r_phase    <= '0;
            r_led      <= 1'b0;
            r_cursor   <= '0;
            r_pattern  <= mlss_pkg::PATTERN_RESET;
            r_idx      <= '0;
            r_dark_vld <= '0;
            r_lit_vld  <= '0;
            r_filt_vld <= '0;
            r_o_valid  <= 1'b0;
        end else if (i_cfg_we) begin
            r_state    <= mlss_pkg::ST_IDLE;
            r_mode     <= mlss_pkg::t_mode'(i_cfg_wdata);
            r_phase    <= '0;
            r_led      <= 1'b0;
            r_cursor   <= '0;
            r_pattern  <= mlss_pkg::PATTERN_RESET;
            r_idx      <= '0;
            r_dark_vld <= '0;
            r_lit_vld  <= '0;
            r_filt_vld <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((in_acc && !frame_start) || calc_go) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (in_acc) begin
                if (frame_start) begin
                    r_led     <= n_led;
                    r_pattern <= n_pattern;
                    r_cursor  <= '0;
                    r_phase   <= 7'd1;
                    r_idx     <= '0;
                end else begin
                    if (r_phase < 7'(mlss_pkg::WAIT_STATES)) begin
                        r_phase <= r_phase + 7'd1;
                    end else if (cur_wrap) begin
                        r_phase  <= '0;
                        r_cursor <= '0;
                    end else begin
                        r_cursor <= cur_inc;
                    end
                end
            end
            if (store_we) begin
                if (r_led) begin
                    r_lit_vld[r_cursor[AW-1:0]] <= 1'b1;
                end else begin
                    r_dark_vld[r_cursor[AW-1:0]] <= 1'b1;
                end
            end
            if (calc_go) begin
                r_filt_vld[r_idx] <= 1'b1;
                if (!idx_last) begin
                    r_idx <= r_idx + AW'(1);
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc && !frame_start) begin
            r_has_values   <= 1'b0;
            r_sensor_index <= '0;
            r_raw          <= '0;
            r_filt         <= '0;
            r_led_drive    <= r_led;
            r_last         <= 1'b1;
            if (r_phase < 7'(mlss_pkg::WAIT_STATES) || cur_wrap) begin
                r_next_ch <= (r_phase < 7'(mlss_pkg::WAIT_STATES)) ? r_cursor : '0;
            end else begin
                r_next_ch <= cur_inc;
            end
        end else if (calc_go) begin
            r_has_values   <= 1'b1;
            r_sensor_index <= 4'(r_idx);
            r_raw          <= clamp_diff(ds, ls);
            r_filt         <= clamp_diff(df_new, lf_new);
            r_next_ch      <= '0;
            r_led_drive    <= r_led;
            r_last         <= idx_last;
        end
    end

    assign o_valid               = r_o_valid;
    assign o_has_values          = r_has_values;
    assign o_sensor_index        = r_sensor_index;
    assign o_raw_difference      = r_raw;
    assign o_filtered_difference = r_filt;
    assign o_next_channel        = r_next_ch;
    assign o_led_drive           = r_led_drive;
    assign o_last                = r_last;

endmodule

@@ design/mlss_checker.sv @@
// port level checks for the modulated led sensor scanner
module mlss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_has_values,
    input logic [3:0]  o_sensor_index,
    input logic [11:0] o_raw_difference,
    input logic [11:0] o_filtered_difference,
    input logic [3:0]  o_next_channel,
    input logic        o_led_drive,
    input logic        o_last
);

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a wait or store item is a single, empty result
    a_plain_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_values |-> o_last && o_sensor_index == 4'd0
            && o_raw_difference == 12'd0 && o_filtered_difference == 12'd0)
        else $error("wait or store result carries values");

    // frame results restart the channel scan and end on the last sensor
    a_frame_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_values |-> o_next_channel == 4'd0
            && (o_last == (o_sensor_index == 4'(mlss_pkg::SENSOR_COUNT - 1))))
        else $error("frame result has wrong channel or last flag");

    // no new sample is taken while a frame is still being emitted
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_cfg_we)
        o_valid && o_has_values && !o_last |-> o_stall)
        else $error("sample accepted during frame output");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_cfg_we)
        o_valid && i_stall |=> o_valid && $stable(o_raw_difference) && $stable(o_last)
            && $stable(o_has_values) && $stable(o_sensor_index)
            && $stable(o_filtered_difference) && $stable(o_next_channel)
            && $stable(o_led_drive))
        else $error("stalled result changed");

endmodule

bind modulated_led_sensor_scanner_unit mlss_checker u_mlss_checker (.*);

@@ bench/modulated_led_sensor_scanner_unit_tb.sv @@
// testbench for the modulated led sensor scanner: directed table, then random samples
`timescale 1ns / 1ps

module modulated_led_sensor_scanner_unit_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 30;
    localparam int PRINT_CAP     = 30;

    typedef struct packed {
        logic        has_values;
        logic [3:0]  sensor_index;
        logic [11:0] raw_diff;
        logic [11:0] filt_diff;
        logic [3:0]  next_channel;
        logic        led_drive;
        logic        last;
    } t_reading;

    typedef enum logic {ROW_SAMPLE, ROW_MODE} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        logic [11:0]     value;
        mlss_pkg::t_mode mode;
        logic            typed;
        t_reading        proto;
    } t_row;

    // hand-written results; sensor_index and last are filled in per result
    localparam t_reading NO_PROTO    = '0;
    localparam t_reading FRAME_DARK  = '{1'b1, 4'd0, 12'd4095, 12'd4095, 4'd0, 1'b0, 1'b0};
    localparam t_reading FRAME_LIT   = '{1'b1, 4'd0, 12'd4095, 12'd4095, 4'd0, 1'b1, 1'b0};
    localparam t_reading WAIT_DARK   = '{1'b0, 4'd0, 12'd0, 12'd0, 4'd0, 1'b0, 1'b0};
    localparam t_reading STORE0_DARK = '{1'b0, 4'd0, 12'd0, 12'd0, 4'd1, 1'b0, 1'b0};

    t_row script [25] = '{
        '{ROW_SAMPLE, 12'hFFF, mlss_pkg::MODE_OFF, 1'b1, FRAME_DARK},
        '{ROW_SAMPLE, 12'h000, mlss_pkg::MODE_OFF, 1'b1, WAIT_DARK},
        '{ROW_SAMPLE, 12'hAAA, mlss_pkg::MODE_OFF, 1'b1, WAIT_DARK},
        '{ROW_SAMPLE, 12'h555, mlss_pkg::MODE_OFF, 1'b1, WAIT_DARK},
        '{ROW_SAMPLE, 12'hFFF, mlss_pkg::MODE_OFF, 1'b1, STORE0_DARK},
        '{ROW_SAMPLE, 12'h000, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h800, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h7FF, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h001, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'hFFE, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h123, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'hABC, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h3C3, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'hC3C, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h000, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'hFFF, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h0F0, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'hF0F, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_MODE,   12'h000, mlss_pkg::MODE_ON,   1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'hFFF, mlss_pkg::MODE_OFF, 1'b1, FRAME_LIT},
        '{ROW_MODE,   12'h000, mlss_pkg::MODE_LFSR, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h000, mlss_pkg::MODE_OFF, 1'b1, FRAME_LIT},
        '{ROW_MODE,   12'h000, mlss_pkg::MODE_OFF, 1'b0, NO_PROTO},
        '{ROW_SAMPLE, 12'h7FF, mlss_pkg::MODE_OFF, 1'b1, FRAME_DARK},
        '{ROW_SAMPLE, 12'h800, mlss_pkg::MODE_OFF, 1'b1, WAIT_DARK}
    };

    int gap_pct_by_profile [4]   = '{0, 50, 0, 27};
    int stall_pct_by_profile [4] = '{0, 0, 50, 27};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] adc_sample = 12'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_has_values;
    logic [3:0]  out_sensor_index;
    logic [11:0] out_raw_difference;
    logic [11:0] out_filtered_difference;
    logic [3:0]  out_next_channel;
    logic        out_led_drive;
    logic        out_last;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int readings_seen = 0;
    int cycles = 0;

    t_reading awaited_readings[$];
    t_reading predicted_now[$];

    // mirror of the scanner state
    mlss_pkg::t_mode                mirror_mode;
    logic [mlss_pkg::PHASE_W-1:0]   mirror_phase;
    logic                           mirror_led;
    logic [mlss_pkg::CURSOR_W-1:0]  mirror_cursor;
    logic [31:0]                    mirror_pattern;
    logic [mlss_pkg::DARK_W-1:0]    mirror_dark [mlss_pkg::SENSOR_COUNT];
    logic [mlss_pkg::SAMPLE_W-1:0]  mirror_lit [mlss_pkg::SENSOR_COUNT];
    logic [mlss_pkg::DARK_W-1:0]    mirror_dark_avg [mlss_pkg::SENSOR_COUNT];
    logic [mlss_pkg::SAMPLE_W-1:0]  mirror_lit_avg [mlss_pkg::SENSOR_COUNT];

    modulated_led_sensor_scanner_unit i_dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_wdata           (cfg_wdata),
        .i_valid               (in_valid),
        .o_stall               (in_stall),
        .i_sample              (adc_sample),
        .o_valid               (out_valid),
        .i_stall               (out_stall),
        .o_has_values          (out_has_values),
        .o_sensor_index        (out_sensor_index),
        .o_raw_difference      (out_raw_difference),
        .o_filtered_difference (out_filtered_difference),
        .o_next_channel        (out_next_channel),
        .o_led_drive           (out_led_drive),
        .o_last                (out_last)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void clear_mirror();
        mirror_phase   = '0;
        mirror_led     = 1'b0;
        mirror_cursor  = '0;
        mirror_pattern = mlss_pkg::PATTERN_RESET;
        for (int i = 0; i < mlss_pkg::SENSOR_COUNT; i++) begin
            mirror_dark[i]     = mlss_pkg::DARK_RESET;
            mirror_lit[i]      = '0;
            mirror_dark_avg[i] = mlss_pkg::DARK_RESET;
            mirror_lit_avg[i]  = '0;
        end
    endfunction

    function automatic logic [11:0] clip_excess(input int a, input int b);
        int d;
        d = a - b;
        if (d < 0) d = 0;
        if (d > 4095) d = 4095;
        return 12'(d);
    endfunction

    function automatic void predict_readings(input logic [11:0] value);
        t_reading r;
        logic     fb;
        predicted_now.delete();
        if (mirror_phase == 0) begin
            case (mirror_mode)
                mlss_pkg::MODE_OFF: mirror_led = 1'b0;
                mlss_pkg::MODE_ON: mirror_led = 1'b1;
                mlss_pkg::MODE_ALTERNATE: begin
                    mirror_pattern = mirror_pattern + 32'd1;
                    mirror_led = mirror_pattern[0];
                end
                default: begin
                    fb = mirror_pattern[31] ^ mirror_pattern[21] ^ mirror_pattern[1]
                        ^ mirror_pattern[0];
                    mirror_pattern = {mirror_pattern[30:0], fb};
                    mirror_led = fb;
                end
            endcase
            mirror_cursor = '0;
            mirror_phase  = 7'd1;
            for (int i = 0; i < mlss_pkg::SENSOR_COUNT; i++) begin
                mirror_dark_avg[i] =
                    13'((7 * int'(mirror_dark_avg[i]) + int'(mirror_dark[i])) >> 3);
                mirror_lit_avg[i]  =
                    12'((7 * int'(mirror_lit_avg[i]) + int'(mirror_lit[i])) >> 3);
                r.has_values   = 1'b1;
                r.sensor_index = 4'(i);
                r.raw_diff     = clip_excess(int'(mirror_dark[i]), int'(mirror_lit[i]));
                r.filt_diff    = clip_excess(int'(mirror_dark_avg[i]), int'(mirror_lit_avg[i]));
                r.next_channel = 4'd0;
                r.led_drive    = mirror_led;
                r.last         = (i == mlss_pkg::SENSOR_COUNT - 1);
                predicted_now.push_back(r);
            end
        end else begin
            if (mirror_phase < mlss_pkg::WAIT_STATES) begin
                mirror_phase = mirror_phase + 7'd1;
            end else begin
                if (mirror_cursor < mlss_pkg::SENSOR_COUNT) begin
                    if (mirror_led) mirror_lit[mirror_cursor] = value;
                    else mirror_dark[mirror_cursor] = {1'b0, value};
                end
                mirror_cursor = mirror_cursor + 4'd1;
                // frame ends once every sensor has one stored sample
                if (mirror_cursor >= mlss_pkg::SENSOR_COUNT || mirror_cursor == 0) begin
                    mirror_phase  = '0;
                    mirror_cursor = '0;
                end
            end
            r = '0;
            r.next_channel = mirror_cursor;
            r.led_drive    = mirror_led;
            r.last         = 1'b1;
            predicted_now.push_back(r);
        end
    endfunction

    task automatic note_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch in %s at result %0d: got %0h, expected %0h",
                     field, readings_seen, got, want);
    endtask

    task automatic push_sample(input logic [11:0] value, input logic typed, input t_reading proto);
        t_reading r;
        int       n;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_readings(value);
        if (typed) begin
            n = proto.has_values ? mlss_pkg::SENSOR_COUNT : 1;
            r = proto;
            for (int k = 0; k < n; k++) begin
                r.sensor_index = proto.has_values ? 4'(k) : 4'd0;
                r.last         = (k == n - 1);
                awaited_readings.push_back(r);
            end
        end else begin
            foreach (predicted_now[k]) awaited_readings.push_back(predicted_now[k]);
        end
    endtask

    // a mode write clears the whole scanner, so only write when it is quiet
    task automatic apply_mode(input mlss_pkg::t_mode m);
        in_valid <= 1'b0;
        while (awaited_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        clear_mirror();
        mirror_mode = m;
    endtask

    always @(posedge clk) begin : result_check
        t_reading got;
        t_reading want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_has_values, out_sensor_index, out_raw_difference,
                    out_filtered_difference, out_next_channel, out_led_drive, out_last};
            if (awaited_readings.size() == 0) begin
                note_mismatch("unexpected item", int'(got), 0);
            end else begin
                want = awaited_readings.pop_front();
                if (got.has_values !== want.has_values)
                    note_mismatch("has_values", got.has_values, want.has_values);
                if (got.sensor_index !== want.sensor_index)
                    note_mismatch("sensor_index", got.sensor_index, want.sensor_index);
                if (got.raw_diff !== want.raw_diff)
                    note_mismatch("raw_difference", got.raw_diff, want.raw_diff);
                if (got.filt_diff !== want.filt_diff)
                    note_mismatch("filtered_difference", got.filt_diff, want.filt_diff);
                if (got.next_channel !== want.next_channel)
                    note_mismatch("next_channel", got.next_channel, want.next_channel);
                if (got.led_drive !== want.led_drive)
                    note_mismatch("led_drive", got.led_drive, want.led_drive);
                if (got.last !== want.last)
                    note_mismatch("last", got.last, want.last);
            end
            readings_seen++;
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        int          n;
        int          profile;
        logic [11:0] value;
        clear_mirror();
        mirror_mode = mlss_pkg::MODE_ALTERNATE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r]) begin
            if (script[r].kind == ROW_MODE) apply_mode(script[r].mode);
            else push_sample(script[r].value, script[r].typed, script[r].proto);
        end

        // each idling profile runs twice, under different modes
        for (int part = 0; part < 8; part++) begin
            profile = part / 2;
            apply_mode(mlss_pkg::t_mode'(2'((part * 3 + 2) % 4)));
            send_gap_pct   = gap_pct_by_profile[profile];
            recv_stall_pct = stall_pct_by_profile[profile];
            n = $urandom_range(50, 38);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(9))
                    0: value = 12'h000;
                    1: value = 12'hFFF;
                    default: value = 12'($urandom_range(4095));
                endcase
                push_sample(value, 1'b0, NO_PROTO);
            end
        end

        in_valid <= 1'b0;
        while (awaited_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
